### hw/rtl/cle_pkg.sv
// Shared constants, codes and types of the console line editor.
`default_nettype none

package cle_pkg;

	localparam int LINE_BYTES = 256;
	localparam int LEN_W      = $clog2(LINE_BYTES);
	localparam int CHAR_W     = 7;
	localparam int BYTE_W     = 8;
	localparam int RES_MAX    = 3;
	localparam int CNT_W      = 2;

	localparam logic [CHAR_W-1:0] CH_NUL  = 7'h00;
	localparam logic [CHAR_W-1:0] CH_BS   = 7'h08;
	localparam logic [CHAR_W-1:0] CH_LF   = 7'h0a;
	localparam logic [CHAR_W-1:0] CH_CR   = 7'h0d;
	localparam logic [CHAR_W-1:0] CH_CTLU = 7'h15;
	localparam logic [CHAR_W-1:0] CH_SP   = 7'h20;
	localparam logic [CHAR_W-1:0] CH_HASH = 7'h23;
	localparam logic [CHAR_W-1:0] CH_AT   = 7'h40;
	localparam logic [CHAR_W-1:0] CH_DEL  = 7'h7f;

	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_DONE = 2'd1,
		KIND_READ = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  value;
	} res_t;

	// Results of one request, handed from the store stage to the emitter.
	typedef struct packed {
		logic [CNT_W-1:0]         n;
		logic                     use_rd;
		res_t [RES_MAX-1:0]       res;
	} plan_t;

endpackage

`default_nettype wire

### hw/rtl/cle_if.sv
// Request and result channel interfaces of the console line editor.
`default_nettype none

interface cle_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [cle_pkg::BYTE_W-1:0]  char_in;
	logic [cle_pkg::BYTE_W-1:0]  read_index;

	modport source (output valid, output mode, output char_in, output read_index,
		input ready);
	modport sink (input valid, input mode, input char_in, input read_index,
		output ready);
endinterface

interface cle_out_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  kind;
	logic [cle_pkg::BYTE_W-1:0]  value;
	logic                        last;

	modport source (output valid, output kind, output value, output last,
		input ready);
	modport sink (input valid, input kind, input value, input last,
		output ready);
endinterface

`default_nettype wire

### hw/rtl/cle_store.sv
// Line store memory, length state and per-request result planning.
`default_nettype none

module cle_store (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	cle_in_if.sink                           in,
	output cle_pkg::plan_t                   plan,
	output logic                             plan_valid,
	input  wire logic                        plan_ready,
	output logic [cle_pkg::CHAR_W-1:0]       rd_data
);
	import cle_pkg::*;

	logic [CHAR_W-1:0] mem [LINE_BYTES];
	logic [CHAR_W-1:0] rd_data_q;
	logic [LEN_W-1:0]  edit_len_q, edit_len_d;
	logic [LEN_W-1:0]  done_len_q, done_len_d;
	plan_t             plan_s1, plan_d;
	logic              plan_valid_q;

	logic              accept;
	logic [CHAR_W-1:0] c;
	logic              is_rub, is_kill, is_plain, len_nz, can_store, wr_en;
	logic [BYTE_W-1:0] in_ch;

	assign in.ready = !plan_valid_q || plan_ready;
	assign accept   = in.valid && in.ready;

	assign c        = (in.char_in[CHAR_W-1:0] == CH_CR) ? CH_LF : in.char_in[CHAR_W-1:0];
	assign in_ch    = BYTE_W'(c);
	assign is_rub   = (c == CH_BS) || (c == CH_DEL);
	assign is_kill  = (c == CH_AT) || (c == CH_CTLU);
	assign is_plain = !(c == CH_NUL || c == CH_LF || is_rub || c == CH_HASH || is_kill);
	assign len_nz   = edit_len_q != '0;
	assign can_store = edit_len_q < LEN_W'(LINE_BYTES - 1);
	assign wr_en    = accept && !in.mode && is_plain && can_store;

	always_comb begin
		plan_d     = '0;
		edit_len_d = edit_len_q;
		done_len_d = done_len_q;
		if (in.mode) begin
			plan_d.n            = CNT_W'(1);
			plan_d.use_rd       = in.read_index < BYTE_W'(done_len_q);
			plan_d.res[0].kind  = KIND_READ;
		end else if (is_rub) begin
			if (len_nz) begin
				edit_len_d    = edit_len_q - LEN_W'(1);
				plan_d.n      = CNT_W'(3);
				plan_d.res[0] = '{kind: KIND_ECHO, value: BYTE_W'(CH_BS)};
				plan_d.res[1] = '{kind: KIND_ECHO, value: BYTE_W'(CH_SP)};
				plan_d.res[2] = '{kind: KIND_ECHO, value: BYTE_W'(CH_BS)};
			end
		end else begin
			plan_d.n      = CNT_W'(1);
			plan_d.res[0] = '{kind: KIND_ECHO, value: in_ch};
			if (c == CH_LF) begin
				done_len_d    = edit_len_q;
				edit_len_d    = '0;
				plan_d.n      = CNT_W'(2);
				plan_d.res[1] = '{kind: KIND_DONE, value: BYTE_W'(edit_len_q)};
			end else if (c == CH_HASH) begin
				if (len_nz) begin
					edit_len_d = edit_len_q - LEN_W'(1);
				end
			end else if (is_kill) begin
				edit_len_d    = '0;
				plan_d.n      = CNT_W'(2);
				plan_d.res[1] = '{kind: KIND_ECHO, value: BYTE_W'(CH_LF)};
			end else if (wr_en) begin
				edit_len_d = edit_len_q + LEN_W'(1);
			end
		end
	end

	// Write and read never hit the same entry at one edge: one request is either.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[edit_len_q] <= c;
		end
		if (accept && in.mode) begin
			rd_data_q <= mem[in.read_index[LEN_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edit_len_q   <= '0;
			done_len_q   <= '0;
			plan_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				edit_len_q   <= edit_len_d;
				done_len_q   <= done_len_d;
				plan_valid_q <= plan_d.n != '0;
			end else if (plan_ready) begin
				plan_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			plan_s1 <= plan_d;
		end
	end

	assign plan       = plan_s1;
	assign plan_valid = plan_valid_q;
	assign rd_data    = rd_data_q;

	a_edit_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edit_len_q <= LEN_W'(LINE_BYTES - 1))
		else $error("edit length beyond store capacity");

	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in.mode && c == CH_LF) |=> (edit_len_q == '0 &&
		done_len_q == $past(edit_len_q)))
		else $error("line end did not move length");

	// Read data matters only for a pending read request.
	a_plan_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(plan_valid_q && !plan_ready) |=> (plan_valid_q && $stable(plan_s1)
		&& (!plan_s1.use_rd || $stable(rd_data_q))))
		else $error("pending plan or read data changed while stalled");

endmodule

`default_nettype wire

### hw/rtl/cle_emit.sv
// Result sequencer: issues a plan's results one per cycle into the output register unless out stalls.
`default_nettype none

module cle_emit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire cle_pkg::plan_t              plan,
	input  wire logic                        plan_valid,
	output logic                             plan_ready,
	input  wire logic [cle_pkg::CHAR_W-1:0]  rd_data,
	cle_out_if.source                        out
);
	import cle_pkg::*;

	res_t [RES_MAX-1:0] res_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   ptr_q;
	logic               out_valid_q;
	kind_t              kind_q;
	logic [BYTE_W-1:0]  value_q;
	logic               last_q;

	logic               load, have, take;
	res_t [RES_MAX-1:0] res_in;

	assign load       = !out_valid_q || out.ready;
	assign have       = rem_q != '0;
	assign take       = plan_valid && (!have || (rem_q == CNT_W'(1) && load));
	assign plan_ready = take;

	always_comb begin
		res_in = plan.res;
		if (plan.use_rd) begin
			res_in[0].value = BYTE_W'(rd_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= have;
			end
			if (load && have) begin
				rem_q <= rem_q - CNT_W'(1);
				ptr_q <= ptr_q + CNT_W'(1);
			end
			// Refill when no result is pending or once the last pending result goes out.
			if (take) begin
				rem_q <= plan.n;
				ptr_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && have) begin
			kind_q  <= res_q[ptr_q].kind;
			value_q <= res_q[ptr_q].value;
			last_q  <= rem_q == CNT_W'(1);
		end
		if (take) begin
			res_q <= res_in;
		end
	end

	assign out.valid = out_valid_q;
	assign out.kind  = kind_q;
	assign out.value = value_q;
	assign out.last  = last_q;

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, ptr_q} + {1'b0, rem_q}) <= (CNT_W + 1)'(RES_MAX))
		else $error("sequencer pointer overran result slots");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		(load && have && rem_q == CNT_W'(1)) |=> (out_valid_q && last_q))
		else $error("final result not marked last");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(have && !load) |=> (rem_q == $past(rem_q)))
		else $error("pending results changed while output stalled");

endmodule

`default_nettype wire

### hw/rtl/console_line_editor_core.sv
// Top level of the console line editor: line store and result sequencer.
//
//   port   dir      payload                      role
//   in     sink     mode, char_in, read_index    typed character or line read request
//   out    source   kind, value, last            echo, line length or read data
//
// One request is taken per cycle while in.ready is high; it yields 0 to 3 results,
// issued one per cycle while out is not stalled. The first result passes the plan
// register, loaded at the accept edge, then the sequencer slots, then the output
// register; the store read port registers its data at the accept edge.
// Reset clears the line and completed lengths; store contents stay undefined.
// A stall on out holds the output register and, once the sequencer and plan
// register are full, drops in.ready.
`default_nettype none

module console_line_editor_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cle_in_if.sink     in,
	cle_out_if.source  out
);
	import cle_pkg::*;

	plan_t             plan;
	logic              plan_valid;
	logic              plan_ready;
	logic [CHAR_W-1:0] rd_data;

	cle_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.in         (in),
		.plan       (plan),
		.plan_valid (plan_valid),
		.plan_ready (plan_ready),
		.rd_data    (rd_data)
	);

	cle_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.plan       (plan),
		.plan_valid (plan_valid),
		.plan_ready (plan_ready),
		.rd_data    (rd_data),
		.out        (out)
	);

endmodule

`default_nettype wire
